[rtl/core/tspf_pkg.sv]
package tspf_pkg;

  typedef enum logic [2:0] {
    KIND_ADD_OK   = 3'd0,
    KIND_ADD_REJ  = 3'd1,
    KIND_FINISH   = 3'd2,
    KIND_VERDICT  = 3'd3,
    KIND_WRAP     = 3'd4
  } kind_e;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_PACKET = 1'b1;

  localparam logic REG_TOTAL_PACKETS = 1'b0;
  localparam logic REG_STUFFING_PID  = 1'b1;

  localparam logic [31:0] TOTAL_PACKETS_RST = 32'd1;
  localparam logic [12:0] STUFFING_PID_RST  = 13'h1FFF;

  typedef struct packed {
    logic        req_type;
    logic [12:0] pid;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    logic [12:0] stream_pid;
    logic [31:0] count;
    logic        matched;
    logic        last;
  } res_t;

  // one filter entry as held in the entry RAM
  typedef struct packed {
    logic [12:0] pid;
    logic [31:0] start_index;
    logic [31:0] routed_count;
  } entry_t;

  typedef struct packed {
    logic push;
    logic rotate;
    logic remove;
  } order_op_t;

endpackage

[rtl/core/tspf_entry_ram.sv]
module tspf_entry_ram #(
  parameter int Depth = 16,
  parameter int IdxW  = 4
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [IdxW-1:0]    waddr_i,
  input  tspf_pkg::entry_t   wdata_i,
  input  logic [IdxW-1:0]    raddr_i,
  output tspf_pkg::entry_t   rdata_o
);

  tspf_pkg::entry_t mem_q [Depth];
  tspf_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tspf_scan_order.sv]
module tspf_scan_order #(
  parameter int Filters = 16,
  parameter int IdxW    = 4,
  parameter int CntW    = 5
) (
  input  logic                  clk_i,
  input  tspf_pkg::order_op_t   op_i,
  input  logic [IdxW-1:0]       push_slot_i,
  input  logic [CntW-1:0]       len_i,
  output logic [IdxW-1:0]       head_o,
  output logic [IdxW-1:0]       next_o
);

  logic [IdxW-1:0] order_q [Filters];
  logic [IdxW-1:0] order_d [Filters];
  logic [IdxW-1:0] nxt     [Filters];
  logic [IdxW-1:0] prv     [Filters];
  logic [CntW-1:0] last_pos;

  for (genvar g = 0; g < Filters; g++) begin : g_nbr
    localparam int Up = (g + 1 < Filters) ? g + 1 : g;
    localparam int Dn = (g > 0) ? g - 1 : 0;
    assign nxt[g] = order_q[Up];
    assign prv[g] = order_q[Dn];
  end

  assign last_pos = len_i - CntW'(1);

  always_comb begin
    for (int i = 0; i < Filters; i++) begin
      order_d[i] = order_q[i];
      if (op_i.push) begin
        order_d[i] = (i == 0) ? push_slot_i : prv[i];
      end else if (op_i.remove) begin
        order_d[i] = nxt[i];
      end else if (op_i.rotate) begin
        // move the head to the tail of the live part of the list
        if (CntW'(i) == last_pos) begin
          order_d[i] = order_q[0];
        end else if (CntW'(i) < last_pos) begin
          order_d[i] = nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Filters; i++) begin
      order_q[i] <= order_d[i];
    end
  end

  assign head_o = order_q[0];
  assign next_o = nxt[0];

endmodule

[rtl/core/tspf_seq.sv]
module tspf_seq #(
  parameter int Filters = 16,
  parameter int IdxW    = 4,
  parameter int CntW    = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tspf_pkg::req_t       req_i,
  input  logic [31:0]          total_packets_i,
  input  logic [12:0]          stuffing_pid_i,
  output logic                 res_valid_o,
  output tspf_pkg::res_t       res_o,
  input  logic [IdxW-1:0]      head_i,
  input  logic [IdxW-1:0]      next_i,
  output tspf_pkg::order_op_t  order_op_o,
  output logic [IdxW-1:0]      push_slot_o,
  output logic [CntW-1:0]      len_o,
  output logic                 ram_we_o,
  output logic [IdxW-1:0]      ram_waddr_o,
  output tspf_pkg::entry_t     ram_wdata_o,
  output logic [IdxW-1:0]      ram_raddr_o,
  input  tspf_pkg::entry_t     ram_rdata_i
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_ADD_SCAN = 6'b000010,
    ST_ADD_DONE = 6'b000100,
    ST_WALK     = 6'b001000,
    ST_VERDICT  = 6'b010000,
    ST_STATS    = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [Filters-1:0]   valid_q, valid_d;
  logic [Filters-1:0]   started_q, started_d;
  logic [CntW-1:0]      active_q, active_d;
  logic [31:0]          index_q, index_d;
  logic [31:0]          stuff_q, stuff_d;
  logic                 res_valid_q, res_valid_d;

  tspf_pkg::res_t       res_q, res_d;
  logic [12:0]          pid_q, pid_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      rem_q, rem_d;
  logic                 dup_q, dup_d;
  logic [IdxW-1:0]      dup_idx_q, dup_idx_d;
  logic                 free_q, free_d;
  logic [IdxW-1:0]      free_idx_q, free_idx_d;
  logic                 taken_q, taken_d;
  logic [IdxW-1:0]      hit_q, hit_d;

  logic [CntW-1:0]      cmp_cnt;
  logic [IdxW-1:0]      cmp_idx;
  logic                 pid_hit;
  logic                 fin;
  logic [31:0]          cnt_new;
  logic [31:0]          start_new;
  logic [31:0]          index_inc;
  logic                 wrap;
  logic                 empty;

  function automatic logic [3:0] to_slot(logic [IdxW-1:0] idx);
    logic [IdxW+3:0] ext;
    ext = {4'b0000, idx};
    return ext[3:0];
  endfunction

  assign cmp_cnt   = cnt_q - CntW'(1);
  assign cmp_idx   = cmp_cnt[IdxW-1:0];
  assign pid_hit   = (ram_rdata_i.pid == pid_q);
  assign fin       = started_q[head_i] && (ram_rdata_i.start_index == index_q);
  assign cnt_new   = ram_rdata_i.routed_count + {31'd0, pid_hit};
  assign start_new = started_q[head_i] ? ram_rdata_i.start_index : index_q;
  assign index_inc = index_q + 32'd1;
  assign wrap      = (index_inc >= total_packets_i);
  assign empty     = (active_q == '0);

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    started_d   = started_q;
    active_d    = active_q;
    index_d     = index_q;
    stuff_d     = stuff_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pid_d       = pid_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dup_d       = dup_q;
    dup_idx_d   = dup_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    taken_d     = taken_q;
    hit_d       = hit_q;
    order_op_o  = '0;
    push_slot_o = free_idx_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = head_i;
    ram_wdata_o = '0;
    ram_raddr_o = head_i;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          pid_d = req_i.pid;
          if (req_i.req_type == tspf_pkg::REQ_PACKET) begin
            if (empty) begin
              res_valid_d = 1'b1;
              res_d       = '{kind: tspf_pkg::KIND_VERDICT, slot: 4'd0,
                              stream_pid: req_i.pid, count: 32'd0,
                              matched: 1'b0, last: 1'b1};
            end else begin
              if (req_i.pid == stuffing_pid_i) begin
                stuff_d = stuff_q + 32'd1;
              end
              rem_d   = active_q;
              taken_d = 1'b0;
              hit_d   = '0;
              state_d = ST_WALK;
            end
          end else if (active_q >= CntW'(Filters)) begin
            res_valid_d = 1'b1;
            res_d       = '{kind: tspf_pkg::KIND_ADD_REJ, slot: 4'd0,
                            stream_pid: req_i.pid, count: 32'd0,
                            matched: 1'b0, last: 1'b1};
          end else begin
            cnt_d   = '0;
            dup_d   = 1'b0;
            free_d  = 1'b0;
            state_d = ST_ADD_SCAN;
          end
        end
      end

      ST_ADD_SCAN: begin
        ram_raddr_o = cnt_q[IdxW-1:0];
        // read data arrives in the cycle after its address is presented
        if (cnt_q != '0) begin
          if (valid_q[cmp_idx] && pid_hit && !dup_q) begin
            dup_d     = 1'b1;
            dup_idx_d = cmp_idx;
          end
          if (!valid_q[cmp_idx] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = cmp_idx;
          end
        end
        if (cnt_q == CntW'(Filters)) begin
          state_d = ST_ADD_DONE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      ST_ADD_DONE: begin
        res_valid_d = 1'b1;
        if (dup_q) begin
          res_d = '{kind: tspf_pkg::KIND_ADD_REJ, slot: to_slot(dup_idx_q),
                    stream_pid: pid_q, count: 32'd0, matched: 1'b0, last: 1'b1};
        end else if (!free_q) begin
          res_d = '{kind: tspf_pkg::KIND_ADD_REJ, slot: 4'd0,
                    stream_pid: pid_q, count: 32'd0, matched: 1'b0, last: 1'b1};
        end else begin
          res_d = '{kind: tspf_pkg::KIND_ADD_OK, slot: to_slot(free_idx_q),
                    stream_pid: pid_q, count: 32'd0, matched: 1'b0, last: 1'b1};
          ram_we_o              = 1'b1;
          ram_waddr_o           = free_idx_q;
          ram_wdata_o.pid       = pid_q;
          valid_d[free_idx_q]   = 1'b1;
          started_d[free_idx_q] = 1'b0;
          order_op_o.push       = 1'b1;
          active_d              = active_q + CntW'(1);
        end
        state_d = ST_IDLE;
      end

      ST_WALK: begin
        // the next head is the current second entry whether we keep or drop
        ram_raddr_o = next_i;
        if (taken_q) begin
          order_op_o.rotate = 1'b1;
        end else begin
          ram_we_o                 = 1'b1;
          ram_wdata_o.pid          = ram_rdata_i.pid;
          ram_wdata_o.start_index  = start_new;
          ram_wdata_o.routed_count = cnt_new;
          if (pid_hit) begin
            taken_d = 1'b1;
            hit_d   = head_i;
          end
          if (fin) begin
            res_valid_d       = 1'b1;
            res_d             = '{kind: tspf_pkg::KIND_FINISH, slot: to_slot(head_i),
                                  stream_pid: ram_rdata_i.pid, count: cnt_new,
                                  matched: 1'b0, last: 1'b0};
            valid_d[head_i]   = 1'b0;
            started_d[head_i] = 1'b0;
            order_op_o.remove = 1'b1;
            active_d          = active_q - CntW'(1);
          end else begin
            started_d[head_i] = 1'b1;
            order_op_o.rotate = 1'b1;
          end
        end
        rem_d = rem_q - CntW'(1);
        if (rem_q == CntW'(1)) begin
          state_d = ST_VERDICT;
        end
      end

      ST_VERDICT: begin
        res_valid_d = 1'b1;
        res_d       = '{kind: tspf_pkg::KIND_VERDICT,
                        slot: taken_q ? to_slot(hit_q) : 4'd0,
                        stream_pid: pid_q, count: 32'd0,
                        matched: taken_q, last: !wrap};
        index_d     = (wrap || empty) ? 32'd0 : index_inc;
        if (wrap) begin
          state_d = ST_STATS;
        end else begin
          if (empty) begin
            stuff_d = 32'd0;
          end
          state_d = ST_IDLE;
        end
      end

      ST_STATS: begin
        res_valid_d = 1'b1;
        res_d       = '{kind: tspf_pkg::KIND_WRAP, slot: 4'd0,
                        stream_pid: stuffing_pid_i, count: stuff_q,
                        matched: 1'b0, last: 1'b1};
        stuff_d     = 32'd0;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      started_q   <= '0;
      active_q    <= '0;
      index_q     <= '0;
      stuff_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      started_q   <= started_d;
      active_q    <= active_d;
      index_q     <= index_d;
      stuff_q     <= stuff_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    pid_q      <= pid_d;
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    dup_q      <= dup_d;
    dup_idx_q  <= dup_idx_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    taken_q    <= taken_d;
    hit_q      <= hit_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign len_o       = active_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/core/ts_pid_filter_one_pass_top.sv]
// Transport-stream PID filter table.
// Request channel: present req_i with start high; the word is taken at the
// clock edge where start is high and busy is low. An add request places a
// filter at the front of the scan order; a packet request walks the filters.
// Result channel: each result word sits on res_o for one cycle with
// res_valid_o high; res_o.last marks the final word of a request. The
// receiver cannot stall, so results are never held back.
// Add: busy while the entry RAM is swept one entry per cycle for a
// duplicate PID and the lowest free entry; the result follows the sweep.
// A full table is rejected in the cycle after acceptance, with no sweep.
// Packet: the live filters are walked in scan order, each one with an
// entry RAM read-modify-write until one takes the packet; then comes the
// verdict, then the wrap statistics if the pass ends, the statistics word
// in the cycle after the verdict. Finish words stream out during the walk.
// An empty table answers a packet in the cycle after acceptance.
// Reset empties the table and clears the packet index and stuffing count;
// total_packets returns to 1 and stuffing_pid to 8191. Write registers over
// the APB port only while busy is low.
module ts_pid_filter_one_pass_top #(
  parameter int FILTERS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tspf_pkg::req_t       req_i,
  output logic                 res_valid_o,
  output tspf_pkg::res_t       res_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int IdxW = (FILTERS > 1) ? $clog2(FILTERS) : 1;
  localparam int CntW = $clog2(FILTERS + 1);

  logic [31:0]          total_q;
  logic [12:0]          stuff_pid_q;
  logic                 reg_sel;
  logic                 wr_en;

  tspf_pkg::order_op_t  order_op;
  logic [IdxW-1:0]      push_slot;
  logic [CntW-1:0]      len;
  logic [IdxW-1:0]      head;
  logic [IdxW-1:0]      next;
  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  tspf_pkg::entry_t     ram_wdata;
  logic [IdxW-1:0]      ram_raddr;
  tspf_pkg::entry_t     ram_rdata;

  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= tspf_pkg::TOTAL_PACKETS_RST;
      stuff_pid_q <= tspf_pkg::STUFFING_PID_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        tspf_pkg::REG_TOTAL_PACKETS: total_q     <= pwdata;
        tspf_pkg::REG_STUFFING_PID:  stuff_pid_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tspf_pkg::REG_TOTAL_PACKETS: prdata = total_q;
      tspf_pkg::REG_STUFFING_PID:  prdata = {19'd0, stuff_pid_q};
      default:                     prdata = '0;
    endcase
  end

  tspf_seq #(
    .Filters (FILTERS),
    .IdxW    (IdxW),
    .CntW    (CntW)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_i           (req_i),
    .total_packets_i (total_q),
    .stuffing_pid_i  (stuff_pid_q),
    .res_valid_o     (res_valid_o),
    .res_o           (res_o),
    .head_i          (head),
    .next_i          (next),
    .order_op_o      (order_op),
    .push_slot_o     (push_slot),
    .len_o           (len),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

  tspf_scan_order #(
    .Filters (FILTERS),
    .IdxW    (IdxW),
    .CntW    (CntW)
  ) u_order (
    .clk_i       (clk_i),
    .op_i        (order_op),
    .push_slot_i (push_slot),
    .len_i       (len),
    .head_o      (head),
    .next_o      (next)
  );

  tspf_entry_ram #(
    .Depth (FILTERS),
    .IdxW  (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
